>>> hw/rtl/aes128_block_cipher_unit_macros.svh
// Assertion macros shared by the cipher unit.
`ifndef AES128_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES128_BLOCK_CIPHER_UNIT_MACROS_SVH
// Check that a condition implies another one at the same edge.
`define AES_ASSERT_IMPLY(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies another one at the next edge.
`define AES_ASSERT_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/aes_pkg.sv
// Package with AES request codes, S-box tables and round helper functions.
`default_nettype none
package aes_pkg;

    localparam int ROUND_KEYS = 11;
    localparam int KEY_WORDS  = 2 * ROUND_KEYS;
    localparam int KADDR_W    = $clog2(KEY_WORDS);
    localparam int ROUND_W    = 4;

    typedef enum logic [1:0] {
        REQ_LOAD_KEY = 2'd0,
        REQ_ENCRYPT  = 2'd1,
        REQ_DECRYPT  = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    typedef logic [127:0] blk_t;

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] a);
        return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    endfunction

    // Multiply by a small constant (up to 4 bits).
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        x2 = xt(a);
        x4 = xt(x2);
        x8 = xt(x4);
        p  = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00)
           ^ (b[3] ? x8 : 8'h00);
        return p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Byte n of a block: byte 0 is the top byte.
    function automatic logic [7:0] bget(input blk_t b, input int n);
        return b[127 - 8 * n -: 8];
    endfunction

    // Forward round: SubBytes, ShiftRows, optional MixColumns.
    function automatic blk_t enc_round(input blk_t s, input logic mix);
        blk_t t;
        blk_t m;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] = SBOX[bget(s, ((c + r) % 4) * 4 + r)];
            end
        end
        m = t;
        for (int c = 0; c < 4; c++) begin
            c0 = bget(t, c * 4);
            c1 = bget(t, c * 4 + 1);
            c2 = bget(t, c * 4 + 2);
            c3 = bget(t, c * 4 + 3);
            m[127 - 8 * (c * 4) -: 8]     = gm(c0, 4'h2) ^ gm(c1, 4'h3) ^ c2 ^ c3;
            m[127 - 8 * (c * 4 + 1) -: 8] = c0 ^ gm(c1, 4'h2) ^ gm(c2, 4'h3) ^ c3;
            m[127 - 8 * (c * 4 + 2) -: 8] = c0 ^ c1 ^ gm(c2, 4'h2) ^ gm(c3, 4'h3);
            m[127 - 8 * (c * 4 + 3) -: 8] = gm(c0, 4'h3) ^ c1 ^ c2 ^ gm(c3, 4'h2);
        end
        return mix ? m : t;
    endfunction

    // Inverse MixColumns on a whole block.
    function automatic blk_t inv_mix(input blk_t t);
        blk_t m;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        for (int c = 0; c < 4; c++) begin
            c0 = bget(t, c * 4);
            c1 = bget(t, c * 4 + 1);
            c2 = bget(t, c * 4 + 2);
            c3 = bget(t, c * 4 + 3);
            m[127 - 8 * (c * 4) -: 8] =
                gm(c0, 4'he) ^ gm(c1, 4'hb) ^ gm(c2, 4'hd) ^ gm(c3, 4'h9);
            m[127 - 8 * (c * 4 + 1) -: 8] =
                gm(c0, 4'h9) ^ gm(c1, 4'he) ^ gm(c2, 4'hb) ^ gm(c3, 4'hd);
            m[127 - 8 * (c * 4 + 2) -: 8] =
                gm(c0, 4'hd) ^ gm(c1, 4'h9) ^ gm(c2, 4'he) ^ gm(c3, 4'hb);
            m[127 - 8 * (c * 4 + 3) -: 8] =
                gm(c0, 4'hb) ^ gm(c1, 4'hd) ^ gm(c2, 4'h9) ^ gm(c3, 4'he);
        end
        return m;
    endfunction

    // Inverse ShiftRows followed by inverse SubBytes.
    function automatic blk_t dec_sub(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] = ISBOX[bget(s, ((c + 4 - r) % 4) * 4 + r)];
            end
        end
        return t;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/aes128_block_cipher_unit.sv
// AES-128 encrypt and decrypt core with a stored round key memory.
//
// Channel   Direction   Ports
// s_        in          s_valid s_ready s_req_type s_key_round s_data_hi s_data_lo
// m_        out         m_valid m_ready m_out_hi m_out_lo
//
// A key load is written into the key memory on accept and leaves the engine idle.
// After a block's accept, one registered key memory read per step paces eleven key
// steps, then the block moves into the output register in ST_WAIT once that register
// is free. A new beat is taken only after the engine is back in ST_IDLE.
// Reset clears control only; the key memory holds garbage until loaded.
// A finished result waits in the output register; a new beat is taken
// once the engine is idle, even while that result is still waiting.
`default_nettype none
`include "aes128_block_cipher_unit_macros.svh"
module aes128_block_cipher_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [3:0]  s_key_round,
    input  wire logic [63:0] s_data_hi,
    input  wire logic [63:0] s_data_lo,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_hi,
    output logic [63:0]      m_out_lo
);
    import aes_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

    // Key memory: one 128-bit row per round key.
    logic [127:0] key_mem [ROUND_KEYS];
    logic [127:0] key_rd_reg;

    state_t       state_reg, state_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [ROUND_W-1:0] raddr;
    logic         dec_reg;
    blk_t         blk_reg, blk_next;
    logic         m_valid_reg;
    blk_t         out_reg;
    logic         s_fire;
    logic         done;
    logic         is_load;
    logic         is_blk;
    logic         first_reg;

    assign s_fire  = s_valid && s_ready;
    assign is_load = s_req_type == REQ_LOAD_KEY;
    assign is_blk  = s_req_type == REQ_ENCRYPT || s_req_type == REQ_DECRYPT;
    assign s_ready = (state_reg == ST_IDLE);

    // Key memory write on load and registered read.
    always_ff @(posedge aclk) begin
        if (s_fire && is_load && s_key_round < ROUND_W'(ROUND_KEYS)) begin
            key_mem[s_key_round] <= {s_data_hi, s_data_lo};
        end
        key_rd_reg <= key_mem[raddr];
    end

    // Key row to read: step k of encryption uses key k, decryption key 10-k.
    always_comb begin
        logic [ROUND_W-1:0] step;
        step = (state_reg == ST_IDLE) ? '0 : rnd_reg;
        if (state_reg == ST_IDLE) begin
            raddr = (s_req_type == REQ_DECRYPT) ? ROUND_W'(ROUND_KEYS - 1) : '0;
        end else begin
            raddr = dec_reg ? ROUND_W'(ROUND_KEYS - 1) - step : step;
        end
    end

    // Round datapath: rnd_reg counts key steps already read.
    always_comb begin
        blk_t t;
        t          = '0;
        blk_next   = blk_reg;
        rnd_next   = rnd_reg;
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && is_blk) begin
                    blk_next   = {s_data_hi, s_data_lo};
                    rnd_next   = ROUND_W'(1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // key_rd_reg holds key for step rnd_reg-1.
                if (first_reg) begin
                    t = blk_reg;
                end else if (!dec_reg) begin
                    t = enc_round(blk_reg, rnd_reg != ROUND_W'(ROUND_KEYS));
                end else begin
                    t = dec_sub(blk_reg);
                end
                t = t ^ key_rd_reg;
                if (dec_reg && !first_reg && rnd_reg != ROUND_W'(ROUND_KEYS)) begin
                    t = inv_mix(t);
                end
                blk_next = t;
                rnd_next = rnd_reg + ROUND_W'(1);
                if (rnd_reg == ROUND_W'(ROUND_KEYS)) begin
                    done       = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State, counters and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= '0;
            m_valid_reg <= 1'b0;
            first_reg   <= 1'b0;
            dec_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            first_reg <= (state_reg == ST_IDLE);
            if (s_fire && is_blk) begin
                dec_reg <= s_req_type == REQ_DECRYPT;
            end
            if (state_reg == ST_WAIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        blk_reg <= blk_next;
        if (state_reg == ST_WAIT && (!m_valid_reg || m_ready)) begin
            out_reg <= blk_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_out_hi = out_reg[127:64];
    assign m_out_lo = out_reg[63:0];

    // Checks on control.
    `AES_ASSERT_IMPLY(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `AES_ASSERT_NEXT(a_done_wait, aclk, aresetn, done, state_reg == ST_WAIT)
    `AES_ASSERT_IMPLY(a_rnd_range, aclk, aresetn, state_reg == ST_RUN,
        rnd_reg != '0 && rnd_reg <= ROUND_W'(ROUND_KEYS))

endmodule
`default_nettype wire
